// ===== src/rmic_pkg.sv =====
`timescale 1ns / 1ps
package rmic_pkg;

	localparam int NDIM      = 3;
	localparam int BOX_W     = 11;
	localparam int POS_W     = 10;
	localparam int IDX_W     = 30;
	localparam int PROD_W    = 21;
	localparam int POP_W     = 31;
	localparam int TOT_W     = 31;
	localparam int SH_W      = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXTENT_X = 2'd0,
		REG_EXTENT_Y = 2'd1,
		REG_EXTENT_Z = 2'd2
	} cfg_reg_t;

	// One item in flight: sub-box, coordinates, index and pair products of the box
	typedef struct packed {
		logic                              vld;
		logic                              op;
		logic                              err;
		logic [NDIM-1:0][BOX_W-1:0]        box;
		logic [NDIM-1:0][POS_W-1:0]        crd;
		logic [IDX_W-1:0]                  acc;
		logic [PROD_W-1:0]                 pyz;
		logic [PROD_W-1:0]                 pxz;
		logic [PROD_W-1:0]                 pxy;
	} step_t;

endpackage

// ===== src/rmic_step.sv =====
`timescale 1ns / 1ps
// One bisection of the box per stage
module rmic_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  rmic_pkg::step_t cur,
	output rmic_pkg::step_t nxt_s1
);

	logic [rmic_pkg::NDIM-1:0][rmic_pkg::SH_W-1:0]  k;
	logic [rmic_pkg::NDIM-1:0][rmic_pkg::BOX_W-1:0] p;
	logic [rmic_pkg::BOX_W-1:0]                     bm1;
	logic [rmic_pkg::BOX_W-1:0]                     best;
	logic [1:0]                                     sd;
	logic [rmic_pkg::SH_W-1:0]                      ksd;
	logic [rmic_pkg::PROD_W-1:0]                    other;
	logic [rmic_pkg::POP_W-1:0]                     pop;
	logic                                           upper;
	logic [rmic_pkg::PROD_W-1:0]                    sx, sy, sz;
	rmic_pkg::step_t                                nxt;

	// Find the split dimension and the lower sub-box population
	always_comb begin
		for (int d = 0; d < rmic_pkg::NDIM; d++) begin
			bm1  = cur.box[d] - rmic_pkg::BOX_W'(1);
			k[d] = '0;
			for (int b = 0; b < rmic_pkg::BOX_W; b++) begin
				if (bm1[b]) begin
					k[d] = rmic_pkg::SH_W'(b);
				end
			end
			p[d] = (cur.box[d] > rmic_pkg::BOX_W'(1)) ?
				(rmic_pkg::BOX_W'(1) << k[d]) : '0;
		end
		sd   = 2'd0;
		best = p[0];
		if (p[1] >= best) begin
			sd   = 2'd1;
			best = p[1];
		end
		if (p[2] >= best) begin
			sd   = 2'd2;
			best = p[2];
		end
		ksd = k[sd];
		case (sd)
			2'd0:    other = cur.pyz;
			2'd1:    other = cur.pxz;
			default: other = cur.pxy;
		endcase
		pop = rmic_pkg::POP_W'(other) << ksd;
		if (cur.op == rmic_pkg::OP_DECODE) begin
			upper = rmic_pkg::POP_W'(cur.acc) >= pop;
		end else begin
			upper = cur.crd[sd] >= rmic_pkg::POS_W'(best);
		end
		sx = rmic_pkg::PROD_W'(cur.box[0]) << ksd;
		sy = rmic_pkg::PROD_W'(cur.box[1]) << ksd;
		sz = rmic_pkg::PROD_W'(cur.box[2]) << ksd;

		// Narrow the box to the half that holds the item
		nxt = cur;
		if (cur.vld && best != '0) begin
			nxt.box[sd] = upper ? (cur.box[sd] - best) : best;
			if (upper) begin
				if (cur.op == rmic_pkg::OP_DECODE) begin
					nxt.acc     = cur.acc - pop[rmic_pkg::IDX_W-1:0];
					nxt.crd[sd] = cur.crd[sd] + rmic_pkg::POS_W'(best);
				end else begin
					nxt.acc     = cur.acc + pop[rmic_pkg::IDX_W-1:0];
					nxt.crd[sd] = cur.crd[sd] - rmic_pkg::POS_W'(best);
				end
			end
			case (sd)
				2'd0: begin
					nxt.pxy = upper ? (cur.pxy - sy) : sy;
					nxt.pxz = upper ? (cur.pxz - sz) : sz;
				end
				2'd1: begin
					nxt.pxy = upper ? (cur.pxy - sx) : sx;
					nxt.pyz = upper ? (cur.pyz - sz) : sz;
				end
				default: begin
					nxt.pxz = upper ? (cur.pxz - sx) : sx;
					nxt.pyz = upper ? (cur.pyz - sy) : sy;
				end
			endcase
		end
	end

	// Advance the stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_s1 <= '0;
		end else if (en) begin
			nxt_s1 <= nxt;
		end
	end

endmodule

// ===== src/rect_morton_index_convert.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Handshake              | Payload
// s        | in  | s_tvalid / s_tready    | s_tdata, s_tuser (opcode)
// m        | out | m_tvalid / m_tready    | m_tdata, m_tuser (range_error)
// cfg      | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item enters per cycle while m is not stalled.
// Three setup stages (extent products, total, range check), then one stage
// per box bisection, DIMS*EXTENT_BITS of them, the last one holds the result.
// A stall at m freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and sets each extent to 1.
module rect_morton_index_convert #(
	parameter int DIMS        = 3,
	parameter int EXTENT_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_x, pos_y, pos_z, index_in, zero pad
	input  logic        s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // index_out, res_x, res_y, res_z, zero pad
	output logic        m_tuser,   // range_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int NSTEP = DIMS * EXTENT_BITS;
	localparam logic [rmic_pkg::BOX_W-1:0] EXT_LIM = rmic_pkg::BOX_W'(1) << EXTENT_BITS;

	logic [rmic_pkg::NDIM-1:0][rmic_pkg::BOX_W-1:0] ext_q;
	logic [rmic_pkg::NDIM-1:0][rmic_pkg::BOX_W-1:0] box;
	logic [rmic_pkg::NDIM-1:0][rmic_pkg::POS_W-1:0] pos;
	logic                                           en;
	logic                                           err0;
	rmic_pkg::step_t                                in_c;
	rmic_pkg::step_t                                item_s1, item_s2, item_s3;
	logic [rmic_pkg::TOT_W-1:0]                     total_s2;
	rmic_pkg::step_t                                st [NSTEP+1];

	assign cfg_ready = 1'b1;
	assign en        = !st[NSTEP].vld || m_tready;
	assign s_tready  = en;

	// Write extent registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < rmic_pkg::NDIM; d++) begin
				ext_q[d] <= rmic_pkg::BOX_W'(1);
			end
		end else if (cfg_valid && cfg_ready) begin
			case (rmic_pkg::cfg_reg_t'(cfg_index))
				rmic_pkg::REG_EXTENT_X: ext_q[0] <= cfg_data;
				rmic_pkg::REG_EXTENT_Y: ext_q[1] <= cfg_data;
				rmic_pkg::REG_EXTENT_Z: ext_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturate extents, treat unused dimensions as one cell, check coordinates
	always_comb begin
		pos[0] = s_tdata[9:0];
		pos[1] = s_tdata[19:10];
		pos[2] = s_tdata[29:20];
		err0   = 1'b0;
		for (int d = 0; d < rmic_pkg::NDIM; d++) begin
			if (d < DIMS) begin
				box[d] = (ext_q[d] > EXT_LIM) ? EXT_LIM : ext_q[d];
			end else begin
				box[d] = rmic_pkg::BOX_W'(1);
			end
			if (box[d] == '0) begin
				err0 = 1'b1;
			end
		end
		in_c.vld = s_tvalid;
		in_c.op  = s_tuser;
		in_c.box = box;
		in_c.acc = (s_tuser == rmic_pkg::OP_DECODE) ? s_tdata[59:30] : '0;
		for (int d = 0; d < rmic_pkg::NDIM; d++) begin
			if (s_tuser == rmic_pkg::OP_ENCODE && d < DIMS) begin
				in_c.crd[d] = pos[d];
				if (rmic_pkg::BOX_W'(pos[d]) >= box[d]) begin
					err0 = 1'b1;
				end
			end else begin
				in_c.crd[d] = '0;
			end
		end
		in_c.err = err0;
		in_c.pyz = rmic_pkg::PROD_W'(box[1]) * rmic_pkg::PROD_W'(box[2]);
		in_c.pxz = rmic_pkg::PROD_W'(box[0]) * rmic_pkg::PROD_W'(box[2]);
		in_c.pxy = rmic_pkg::PROD_W'(box[0]) * rmic_pkg::PROD_W'(box[1]);
	end

	// Setup stages: total population and decode range check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1  <= '0;
			item_s2  <= '0;
			item_s3  <= '0;
			total_s2 <= '0;
		end else if (en) begin
			item_s1  <= in_c;
			item_s2  <= item_s1;
			total_s2 <= rmic_pkg::TOT_W'(item_s1.pxy) * rmic_pkg::TOT_W'(item_s1.box[2]);
			{item_s3.vld, item_s3.op, item_s3.box, item_s3.crd, item_s3.acc,
				item_s3.pyz, item_s3.pxz, item_s3.pxy} <=
				{item_s2.vld, item_s2.op, item_s2.box, item_s2.crd, item_s2.acc,
				item_s2.pyz, item_s2.pxz, item_s2.pxy};
			item_s3.err <= item_s2.err || (item_s2.op == rmic_pkg::OP_DECODE &&
				rmic_pkg::TOT_W'(item_s2.acc) >= total_s2);
		end
	end

	assign st[0] = item_s3;

	// Bisection stages
	for (genvar i = 0; i < NSTEP; i++) begin : g_step
		rmic_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.cur    (st[i]),
			.nxt_s1 (st[i+1])
		);
	end

	// Drive the result, zeroed on a range error
	assign m_tvalid = st[NSTEP].vld;
	assign m_tuser  = st[NSTEP].err;
	always_comb begin
		m_tdata = '0;
		if (!st[NSTEP].err) begin
			if (st[NSTEP].op == rmic_pkg::OP_ENCODE) begin
				m_tdata[29:0] = st[NSTEP].acc;
			end else begin
				m_tdata[39:30] = st[NSTEP].crd[0];
				m_tdata[49:40] = st[NSTEP].crd[1];
				m_tdata[59:50] = st[NSTEP].crd[2];
			end
		end
	end

endmodule

// ===== src/rmic_checker.sv =====
`timescale 1ns / 1ps
module rmic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Zero all fields on a range error
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 64'd0)
		else $error("range error with nonzero data");

	// Accept input whenever the output is free
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with output free");

	// Keep the pad bits clear
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[63:60] == 4'd0)
		else $error("pad bits set");

endmodule

bind rect_morton_index_convert rmic_checker u_rmic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/rect_morton_index_convert_tb.sv =====
`timescale 1ns / 1ps
module rect_morton_index_convert_tb;

	localparam int LATENCY   = 3 + 3 * 10;
	localparam int N_RANDOM  = 800;
	localparam int MAX_CYCLE = 400000;

	typedef struct {
		logic [rmic_pkg::IDX_W-1:0] index;
		logic [rmic_pkg::POS_W-1:0] x;
		logic [rmic_pkg::POS_W-1:0] y;
		logic [rmic_pkg::POS_W-1:0] z;
		logic                       err;
	} zres_t;

	typedef struct {
		logic                       op;
		logic [rmic_pkg::POS_W-1:0] x;
		logic [rmic_pkg::POS_W-1:0] y;
		logic [rmic_pkg::POS_W-1:0] z;
		logic [rmic_pkg::IDX_W-1:0] index;
		logic                       known;
		zres_t                      res;
	} zrow_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	logic [rmic_pkg::BOX_W-1:0] dom_extent [rmic_pkg::NDIM];
	zres_t                      pending_zres [$];
	int                         err_count = 0;
	int                         cycle = 0;

	rect_morton_index_convert dut (.*);

	// free-running clock and timeout
	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > MAX_CYCLE) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle);
		err_count++;
	endtask

	function automatic logic [rmic_pkg::BOX_W-1:0] clip_extent(
			input logic [rmic_pkg::BOX_W-1:0] e);
		return (e > 11'd1024) ? 11'd1024 : e;
	endfunction

	// largest power of two strictly below v, zero for v <= 1
	function automatic logic [rmic_pkg::BOX_W-1:0] split_size(
			input logic [rmic_pkg::BOX_W-1:0] v);
		logic [rmic_pkg::BOX_W-1:0] p;
		p = '0;
		if (v > 11'd1)
			for (int b = 0; b < rmic_pkg::BOX_W; b++)
				if ((11'd1 << b) <= v - 11'd1) p = 11'd1 << b;
		return p;
	endfunction

	// walk the bisection to encode or decode a Z-order index
	function automatic zres_t morton_convert(input logic op,
			input logic [rmic_pkg::POS_W-1:0] px, input logic [rmic_pkg::POS_W-1:0] py,
			input logic [rmic_pkg::POS_W-1:0] pz, input logic [rmic_pkg::IDX_W-1:0] index);
		zres_t                      r;
		logic [rmic_pkg::BOX_W-1:0] box [rmic_pkg::NDIM];
		logic [rmic_pkg::BOX_W-1:0] crd [rmic_pkg::NDIM];
		logic [rmic_pkg::BOX_W-1:0] p2, best;
		longint                     volume, lower, rem;
		int                         sd;
		r = '{default: '0};
		crd[0] = rmic_pkg::BOX_W'(px);
		crd[1] = rmic_pkg::BOX_W'(py);
		crd[2] = rmic_pkg::BOX_W'(pz);
		volume = 1;
		for (int d = 0; d < rmic_pkg::NDIM; d++) begin
			box[d] = clip_extent(dom_extent[d]);
			volume *= box[d];
			if (box[d] == '0) r.err = 1'b1;
			if (op == rmic_pkg::OP_ENCODE && crd[d] >= box[d]) r.err = 1'b1;
		end
		if (op == rmic_pkg::OP_DECODE) begin
			if (longint'(index) >= volume) r.err = 1'b1;
			for (int d = 0; d < rmic_pkg::NDIM; d++) crd[d] = '0;
		end
		if (r.err) return '{default: '0, err: 1'b1};
		rem = longint'(index);
		forever begin
			best = '0; sd = 0;
			for (int d = 0; d < rmic_pkg::NDIM; d++) begin
				p2 = split_size(box[d]);
				if (p2 >= best) begin best = p2; sd = d; end
			end
			if (best == '0) break;
			lower = 1;
			for (int d = 0; d < rmic_pkg::NDIM; d++) lower *= (d == sd) ? best : box[d];
			if (op == rmic_pkg::OP_ENCODE) begin
				if (crd[sd] < best) box[sd] = best;
				else begin
					r.index = r.index + rmic_pkg::IDX_W'(lower);
					crd[sd] -= best;
					box[sd] -= best;
				end
			end else begin
				if (rem < lower) box[sd] = best;
				else begin
					rem -= lower;
					crd[sd] += best;
					box[sd] -= best;
				end
			end
		end
		if (op == rmic_pkg::OP_DECODE) begin
			r.x = crd[0][rmic_pkg::POS_W-1:0];
			r.y = crd[1][rmic_pkg::POS_W-1:0];
			r.z = crd[2][rmic_pkg::POS_W-1:0];
		end
		return r;
	endfunction

	task automatic write_extent(input rmic_pkg::cfg_reg_t reg_id, input logic [10:0] value);
		cfg_index = reg_id;
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		dom_extent[reg_id] = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// wait until every expected result has come
	task automatic drain();
		while (pending_zres.size() != 0) @(negedge clk);
	endtask

	task automatic set_domain(input logic [10:0] ex, input logic [10:0] ey,
			input logic [10:0] ez);
		drain();
		repeat (LATENCY + 4) @(negedge clk);
		write_extent(rmic_pkg::REG_EXTENT_X, ex);
		write_extent(rmic_pkg::REG_EXTENT_Y, ey);
		write_extent(rmic_pkg::REG_EXTENT_Z, ez);
	endtask

	// send one item; an item with a known answer carries it, else predict
	task automatic send_item(input zrow_t row);
		zres_t want;
		repeat ($urandom_range(0, 4)) @(negedge clk);
		want = row.known ? row.res : morton_convert(row.op, row.x, row.y, row.z, row.index);
		s_tdata  = {4'd0, row.index, row.z, row.y, row.x};
		s_tuser  = row.op;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_zres = {pending_zres, want};
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	function automatic zrow_t make_row(input logic op, input int x, input int y, input int z,
			input int index);
		zrow_t row;
		row = '{op: op, x: rmic_pkg::POS_W'(x), y: rmic_pkg::POS_W'(y),
			z: rmic_pkg::POS_W'(z), index: rmic_pkg::IDX_W'(index), known: 1'b0,
			res: '{default: '0}};
		return row;
	endfunction

	function automatic zrow_t fixed_row(input zrow_t row,
			input logic [rmic_pkg::IDX_W-1:0] index, input int x, input int y, input int z,
			input logic err);
		row.known = 1'b1;
		row.res = '{index: index, x: rmic_pkg::POS_W'(x), y: rmic_pkg::POS_W'(y),
			z: rmic_pkg::POS_W'(z), err: err};
		return row;
	endfunction

	// drain side: hold m_tready low for a random wait before taking each result
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
			m_tready = 1'b1;
			do @(posedge clk); while (!(m_tvalid && arst_n));
		end
	end

	// check each result transfer
	always @(posedge clk) begin
		zres_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_zres.size() == 0) begin
				report("unexpected result", m_tdata, 0);
			end else begin
				want = pending_zres.pop_front();
				if (m_tdata[29:0] !== want.index) report("index_out", m_tdata[29:0], want.index);
				if (m_tdata[39:30] !== want.x) report("res_x", m_tdata[39:30], want.x);
				if (m_tdata[49:40] !== want.y) report("res_y", m_tdata[49:40], want.y);
				if (m_tdata[59:50] !== want.z) report("res_z", m_tdata[59:50], want.z);
				if (m_tdata[63:60] !== 4'd0) report("pad", m_tdata[63:60], 0);
				if (m_tuser !== want.err) report("range_error", m_tuser, want.err);
			end
		end
	end

	initial begin
		zrow_t            drill [$];
		zrow_t            row;
		logic [10:0]      ex, ey, ez;
		longint           volume;
		int               sent;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		for (int d = 0; d < rmic_pkg::NDIM; d++) dom_extent[d] = 11'd1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// after reset the domain is a single cell
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_ENCODE, 0, 0, 0, 0), 0, 0, 0, 0, 0)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 0), 0, 0, 0, 0, 0)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_ENCODE, 1, 0, 0, 0), 0, 0, 0, 0, 1)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 1), 0, 0, 0, 0, 1)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_ENCODE, 1023, 1023, 1023, 0),
			0, 0, 0, 0, 1)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_DECODE, 1023, 1023, 1023,
			30'h3fffffff), 0, 0, 0, 0, 1)};
		foreach (drill[i]) send_item(drill[i]);
		drill.delete();

		// largest domain, oversized extent saturates to 1024
		set_domain(11'd2047, 11'd1024, 11'd1025);
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_ENCODE, 0, 0, 0, 0), 0, 0, 0, 0, 0)};
		drill = {drill, make_row(rmic_pkg::OP_ENCODE, 1023, 1023, 1023, 0)};
		drill = {drill, make_row(rmic_pkg::OP_ENCODE, 1, 0, 0, 0)};
		drill = {drill, make_row(rmic_pkg::OP_ENCODE, 0, 0, 1, 0)};
		drill = {drill, make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 30'h3fffffff)};
		drill = {drill, make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 1)};
		drill = {drill, make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 30'h15555555)};
		foreach (drill[i]) send_item(drill[i]);
		drill.delete();

		// non power of two domain with a zero extent, then odd sizes
		set_domain(11'd5, 11'd0, 11'd3);
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_ENCODE, 0, 0, 0, 0), 0, 0, 0, 0, 1)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 0), 0, 0, 0, 0, 1)};
		foreach (drill[i]) send_item(drill[i]);
		drill.delete();
		set_domain(11'd5, 11'd7, 11'd3);
		drill = {drill, make_row(rmic_pkg::OP_ENCODE, 4, 6, 2, 0)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_ENCODE, 5, 0, 0, 0), 0, 0, 0, 0, 1)};
		drill = {drill, make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 104)};
		drill = {drill, fixed_row(make_row(rmic_pkg::OP_DECODE, 0, 0, 0, 105),
			0, 0, 0, 0, 1)};
		foreach (drill[i]) send_item(drill[i]);
		drill.delete();

		// random part: new domain every phase, mostly in-range items
		sent = 0;
		while (sent < N_RANDOM) begin
			case ($urandom_range(0, 5))
				0: begin ex = 11'd1024; ey = 11'd1024; ez = 11'd1024; end
				1: begin ex = 11'($urandom_range(0, 2047)); ey = 11'($urandom_range(0, 2047));
					ez = 11'($urandom_range(0, 2047)); end
				2: begin ex = 11'd1; ey = 11'($urandom_range(1, 1024)); ez = 11'd1; end
				default: begin ex = 11'($urandom_range(1, 40)); ey = 11'($urandom_range(1, 40));
					ez = 11'($urandom_range(1, 40)); end
			endcase
			set_domain(ex, ey, ez);
			volume = longint'(clip_extent(ex)) * clip_extent(ey) * clip_extent(ez);
			repeat (80) begin
				row = make_row(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 30'h3fffffff));
				if ($urandom_range(0, 9) != 0 && volume != 0) begin
					row.x = rmic_pkg::POS_W'($urandom_range(0, clip_extent(ex) - 1));
					row.y = rmic_pkg::POS_W'($urandom_range(0, clip_extent(ey) - 1));
					row.z = rmic_pkg::POS_W'($urandom_range(0, clip_extent(ez) - 1));
					row.index = rmic_pkg::IDX_W'($urandom_range(0, int'(volume - 1)));
				end
				send_item(row);
				sent++;
			end
			// hold the sender until the pipe drains once
			if (sent == 400) begin
				drain();
			end
		end

		drain();
		repeat (LATENCY + 10) @(negedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
